// File: hdl/hrc_pkg.sv
// ----------------------------------------------------------------------------
// Heater runaway checker package
// Field widths, register indexes, fault codes and fixed limits shared by the
// checker.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int TEMP_W   = 15;
    localparam int GOAL_W   = 16;
    localparam int HYST_W   = 10;
    localparam int ERR_W    = 21;
    localparam int GAIN_W   = 10;
    localparam int WINDOW_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    // Readings below -20 degrees (1/16 degree units) are taken as a broken sensor.
    localparam logic signed [16:0] SENSOR_FLOOR = -17'sd320;

    // Saturation limit of the accumulated shortfall.
    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    // Register reset values.
    localparam logic [HYST_W-1:0]   HYST_RESET   = 10'd80;
    localparam logic [ERR_W-1:0]    MAX_ERR_RESET = 21'd1920;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd32;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HYSTERESIS      = 2'd0,
        REG_SHORTFALL_LIMIT = 2'd1,
        REG_RISE_STEP       = 2'd2,
        REG_GAIN_WINDOW     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_SENSOR  = 2'd1,
        FAULT_HEATING = 2'd2
    } fault_t;

endpackage

// File: hdl/heater_runaway_checker.sv
// ----------------------------------------------------------------------------
// Heater runaway checker
// Thermal runaway protection for one heater: tracks the shortfall against the
// target and the progress of each approach, and latches a fault.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  -------   ---------  ---------------------------------------------------
//  s_*       in         one check tick: temperature, target_temp
//  m_*       out        one result per tick: fault_code, approaching
//  cfg_*     in         register writes: hysteresis, shortfall limit, rise step,
//                       gain window
//
// From acceptance to its result a tick passes through the input register,
// where the whole check is evaluated, and then through the result register.
// One item can be accepted each cycle while results are taken, as the check is
// a single pass of compare-and-add logic. When both registers are full and the
// result is not taken, s_tready falls and the tick waits in the input register.
// Reset clears all tracking state and loads the register defaults.
module heater_runaway_checker
    import hrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [14:0] temperature, [29:15] target_temp

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] fault_code, [2] approaching

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [HYST_W-1:0]   hysteresis_reg;
    logic [ERR_W-1:0]    shortfall_limit_reg;
    logic [GAIN_W-1:0]   rise_step_reg;
    logic [WINDOW_W-1:0] gain_window_reg;

    // Input register.
    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic signed [TEMP_W-1:0] in_target_reg;

    // Result register.
    logic                     out_valid_reg;
    fault_t                   out_fault_reg;
    logic                     out_approach_reg;

    // Tracking state and its next values.
    logic                     approach_reg,   approach_next;
    logic                     starting_reg,   starting_next;
    logic signed [TEMP_W-1:0] prev_target_reg, prev_target_next;
    logic signed [GOAL_W-1:0] goal_reg,       goal_next;
    logic [ERR_W-1:0]         error_sum_reg,  error_sum_next;
    logic [WINDOW_W-1:0]      ticks_reg,      ticks_next;
    fault_t                   latched_reg,    latched_next;

    // Datapath.
    logic                     advance;
    logic signed [16:0]       temp_x;
    logic signed [16:0]       target_x;
    logic signed [16:0]       hyst_x;
    logic signed [16:0]       lo_bound;
    logic signed [16:0]       hi_bound;
    logic signed [16:0]       shortfall;
    logic [ERR_W:0]           sum_wide;
    logic [ERR_W-1:0]         err_sat;
    logic signed [GOAL_W-1:0] temp16;
    logic signed [GOAL_W-1:0] next_goal;
    logic [WINDOW_W-1:0]      ticks_dec;
    logic                     target_off;
    logic                     near_target;

    // The input item moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_approach_reg, out_fault_reg};

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hysteresis_reg      <= HYST_RESET;
            shortfall_limit_reg <= MAX_ERR_RESET;
            rise_step_reg       <= GAIN_RESET;
            gain_window_reg     <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_HYSTERESIS:      hysteresis_reg      <= cfg_wdata[HYST_W-1:0];
                REG_SHORTFALL_LIMIT: shortfall_limit_reg <= cfg_wdata[ERR_W-1:0];
                REG_RISE_STEP:       rise_step_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_WINDOW:     gain_window_reg     <= cfg_wdata[WINDOW_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one tick while the check is evaluated.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_temp_reg   <= s_tdata[TEMP_W-1:0];
            in_target_reg <= s_tdata[2*TEMP_W-1:TEMP_W];
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic of the check. All comparisons are done on 17-bit signed
    // values so that target plus or minus the band cannot wrap.
    // ------------------------------------------------------------------
    always_comb
    begin
        temp_x    = {{2{in_temp_reg[TEMP_W-1]}}, in_temp_reg};
        target_x  = {{2{in_target_reg[TEMP_W-1]}}, in_target_reg};
        hyst_x    = {7'd0, hysteresis_reg};
        lo_bound  = target_x - hyst_x;
        hi_bound  = target_x + hyst_x;
        // Positive and below 2^15 whenever it is used.
        shortfall = lo_bound - temp_x;
        sum_wide  = {1'b0, error_sum_reg} + {6'd0, shortfall[14:0]};
        err_sat   = sum_wide[ERR_W] ? ERR_MAX : sum_wide[ERR_W-1:0];
        temp16    = {in_temp_reg[TEMP_W-1], in_temp_reg};
        next_goal = temp16 + $signed({6'd0, rise_step_reg});
        ticks_dec = (ticks_reg != '0) ? ticks_reg - 16'd1 : '0;
        target_off  = in_target_reg[TEMP_W-1] || (in_target_reg == '0);
        near_target = (temp_x >= lo_bound);
    end

    // ------------------------------------------------------------------
    // Next state of the tracker, taken when the tick leaves the input
    // register.
    // ------------------------------------------------------------------
    always_comb
    begin
        approach_next    = approach_reg;
        starting_next    = starting_reg;
        prev_target_next = prev_target_reg;
        goal_next        = goal_reg;
        error_sum_next   = error_sum_reg;
        ticks_next       = ticks_reg;
        latched_next     = latched_reg;

        if (advance)
        begin
            priority if (latched_reg != FAULT_NONE)
            begin
                // A latched fault freezes everything.
            end
            else if (temp_x < SENSOR_FLOOR)
            begin
                latched_next = FAULT_SENSOR;
            end
            else if (near_target || target_off)
            begin
                approach_next    = 1'b0;
                starting_next    = 1'b0;
                prev_target_next = in_target_reg;
                if (temp_x <= hi_bound)
                begin
                    error_sum_next = '0;
                end
            end
            else
            begin
                error_sum_next = err_sat;
                if (!approach_reg)
                begin
                    priority if (in_target_reg != prev_target_reg)
                    begin
                        // A new target starts an approach.
                        approach_next    = 1'b1;
                        starting_next    = 1'b1;
                        goal_next        = next_goal;
                        ticks_next       = gain_window_reg;
                        prev_target_next = in_target_reg;
                    end
                    else if (err_sat >= shortfall_limit_reg)
                    begin
                        latched_next = FAULT_HEATING;
                    end
                    else
                    begin
                        prev_target_next = in_target_reg;
                    end
                end
                else
                begin
                    prev_target_next = in_target_reg;
                    priority if (temp16 >= goal_reg)
                    begin
                        // Progress renews the goal and the countdown.
                        starting_next  = 1'b0;
                        error_sum_next = '0;
                        goal_next      = next_goal;
                        ticks_next     = gain_window_reg;
                    end
                    else if (ticks_dec == '0)
                    begin
                        approach_next = 1'b0;
                        ticks_next    = ticks_dec;
                    end
                    else
                    begin
                        ticks_next = ticks_dec;
                        if (starting_reg && (next_goal < goal_reg))
                        begin
                            goal_next = next_goal;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            approach_reg    <= 1'b0;
            starting_reg    <= 1'b0;
            prev_target_reg <= '0;
            goal_reg        <= '0;
            error_sum_reg   <= '0;
            ticks_reg       <= '0;
            latched_reg     <= FAULT_NONE;
        end
        else
        begin
            approach_reg    <= approach_next;
            starting_reg    <= starting_next;
            prev_target_reg <= prev_target_next;
            goal_reg        <= goal_next;
            error_sum_reg   <= error_sum_next;
            ticks_reg       <= ticks_next;
            latched_reg     <= latched_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: the result of a tick is the state after that tick.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_fault_reg    <= latched_next;
            out_approach_reg <= approach_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A latched fault can only be left by reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (latched_reg != FAULT_NONE) |=> (latched_reg == $past(latched_reg)))
        else $error("latched fault changed");

    // Each result reports the tracker state it left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_fault_reg == latched_reg) && (out_approach_reg == approach_reg))
        else $error("result does not match tracker state");

    // The tracker only moves when a tick is evaluated.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(error_sum_reg) && $stable(ticks_reg) && $stable(goal_reg))
        else $error("tracker state changed without a tick");

    // A tick held back by a stalled result stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_temp_reg)
                                       && $stable(in_target_reg))
        else $error("held tick lost");
`endif

endmodule
